FILE: rtl/stq_pkg.sv
// Shared constants, codes and control structs for the sorted timer queue.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned IDW   = 4;
  localparam int unsigned TW    = 32;
  localparam int unsigned EW    = IDW + TW;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_ADJ  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  // table walk modes
  localparam logic [1:0] PASS_SCAN = 2'd0;
  localparam logic [1:0] PASS_EMIT = 2'd1;
  localparam logic [1:0] PASS_MOVE = 2'd2;

  typedef struct packed {
    logic       load;
    logic       pass_go;
    logic [1:0] pass_mode;
    logic       wr_new;
    logic       cnt_upd;
    logic       resp;
    logic       resp_none;
    logic [1:0] resp_st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pass_done;
    logic       found;
    logic       full;
    logic       none_due;
  } sts_t;

endpackage

FILE: rtl/stq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module stq_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stq_ctrl.sv
// Sequencing state machine: search walk, then emit/shift walks, insert write, status.
// Depends on stq_pkg; drives stq_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module stq_ctrl import stq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;

  logic [2:0] state_q, state_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load      = 1'b1;
          cmd.pass_go   = 1'b1;
          cmd.pass_mode = PASS_SCAN;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.pass_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.op)
          OP_TICK: begin
            if (sts_i.none_due) begin
              cmd.resp_none = 1'b1;
              state_d       = S_IDLE;
            end else begin
              cmd.pass_go   = 1'b1;
              cmd.pass_mode = PASS_EMIT;
              state_d       = S_EMIT;
            end
          end
          OP_ADD: begin
            if (sts_i.found) begin
              cmd.resp    = 1'b1;
              cmd.resp_st = ST_PRESENT;
              state_d     = S_IDLE;
            end else if (sts_i.full) begin
              cmd.resp    = 1'b1;
              cmd.resp_st = ST_FULL;
              state_d     = S_IDLE;
            end else begin
              cmd.pass_go   = 1'b1;
              cmd.pass_mode = PASS_MOVE;
              state_d       = S_MOVE;
            end
          end
          default: begin
            if (!sts_i.found) begin
              cmd.resp    = 1'b1;
              cmd.resp_st = ST_ABSENT;
              state_d     = S_IDLE;
            end else begin
              cmd.pass_go   = 1'b1;
              cmd.pass_mode = PASS_MOVE;
              state_d       = S_MOVE;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (sts_i.pass_done) begin
          cmd.pass_go   = 1'b1;
          cmd.pass_mode = PASS_MOVE;
          state_d       = S_MOVE;
        end
      end
      S_MOVE: begin
        if (sts_i.pass_done) begin
          if (sts_i.op == OP_ADD || sts_i.op == OP_ADJ) begin
            state_d = S_WRITE;
          end else begin
            cmd.cnt_upd = 1'b1;
            cmd.resp    = (sts_i.op == OP_DEL);
            cmd.resp_st = ST_OK;
            state_d     = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_upd = 1'b1;
        cmd.resp    = 1'b1;
        cmd.resp_st = ST_OK;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/stq_dp.sv
// Datapath: table RAM, address walker, search results, entry count, result registers.
// Depends on stq_pkg and stq_ram; controlled by stq_ctrl.
`timescale 1ns / 1ps

module stq_dp import stq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic [1:0]      operation_i,
  input  logic [IDW-1:0]  timer_id_i,
  input  logic [TW-1:0]   expire_time_i,
  input  logic [TW-1:0]   now_time_i,
  output logic            res_strobe_o,
  output logic [1:0]      kind_o,
  output logic [IDW-1:0]  fired_id_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  logic [1:0]     op_q;
  logic [IDW-1:0] id_q;
  logic [TW-1:0]  key_q;

  logic [CW-1:0]  cnt_q, cnt_d;

  logic [1:0]     mode_q;
  logic [AW-1:0]  src_q;
  logic [CW-1:0]  left_q;
  logic           up_q;
  logic [AW-1:0]  off_q;

  logic           rd_vld_q;
  logic [AW-1:0]  rd_idx_q;
  logic           rd_last_q;

  logic           found_q;
  logic [AW-1:0]  pos_q;
  logic [CW-1:0]  ins_q;

  logic           strobe_q, strobe_d;
  logic [1:0]     kind_q, kind_d;
  logic [IDW-1:0] fid_q, fid_d;
  logic [1:0]     st_q, st_d;
  logic           last_q, last_d;

  logic [EW-1:0]  rdata;
  logic [IDW-1:0] rd_id;
  logic [TW-1:0]  rd_exp;
  logic [CW-1:0]  pos_ext;
  logic [CW-1:0]  tgt;
  logic [AW-1:0]  go_src;
  logic [CW-1:0]  go_left;
  logic           go_up;
  logic [AW-1:0]  go_off;
  logic [AW-1:0]  wr_dst;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;

  assign rd_id   = rdata[EW-1:TW];
  assign rd_exp  = rdata[TW-1:0];
  assign pos_ext = CW'(pos_q);
  // re-insert slot; for adjust the entry's own slot drops out first
  assign tgt     = (found_q && (pos_ext < ins_q)) ? (ins_q - CW'(1)) : ins_q;

  always_comb begin
    go_src  = '0;
    go_left = '0;
    go_up   = 1'b1;
    go_off  = AW'(1);
    case (cmd_i.pass_mode)
      PASS_SCAN: begin
        go_left = cnt_q;
      end
      PASS_EMIT: begin
        go_left = ins_q;
      end
      PASS_MOVE: begin
        case (op_q)
          OP_ADD: begin
            go_up   = 1'b0;
            go_src  = AW'(cnt_q - CW'(1));
            go_left = cnt_q - ins_q;
          end
          OP_DEL: begin
            go_src  = AW'(pos_ext + CW'(1));
            go_left = cnt_q - pos_ext - CW'(1);
          end
          OP_ADJ: begin
            if (tgt > pos_ext) begin
              go_src  = AW'(pos_ext + CW'(1));
              go_left = tgt - pos_ext;
            end else if (tgt < pos_ext) begin
              go_up   = 1'b0;
              go_src  = AW'(pos_ext - CW'(1));
              go_left = pos_ext - tgt;
            end
          end
          default: begin
            go_src  = AW'(ins_q);
            go_left = cnt_q - ins_q;
            go_off  = AW'(ins_q);
          end
        endcase
      end
      default: ;
    endcase
  end

  // address walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= PASS_SCAN;
      left_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (left_q != '0);
      if (cmd_i.pass_go) begin
        mode_q <= cmd_i.pass_mode;
        left_q <= go_left;
      end else if (left_q != '0) begin
        left_q <= left_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= src_q;
    rd_last_q <= (left_q == CW'(1));
    if (cmd_i.pass_go) begin
      src_q <= go_src;
      up_q  <= go_up;
      off_q <= go_off;
    end else if (left_q != '0) begin
      src_q <= up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
    end
    if (cmd_i.load) begin
      op_q  <= operation_i;
      id_q  <= timer_id_i;
      key_q <= (operation_i == OP_TICK) ? now_time_i : expire_time_i;
    end
  end

  assign wr_dst    = up_q ? (rd_idx_q - off_q) : (rd_idx_q + AW'(1));
  assign ram_we    = (rd_vld_q && (mode_q == PASS_MOVE)) || cmd_i.wr_new;
  assign ram_waddr = cmd_i.wr_new ? AW'(tgt) : wr_dst;
  assign ram_wdata = cmd_i.wr_new ? {id_q, key_q} : rdata;

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (src_q),
    .rdata_o (rdata)
  );

  // search results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      ins_q   <= '0;
    end else if (cmd_i.pass_go && (cmd_i.pass_mode == PASS_SCAN)) begin
      found_q <= 1'b0;
      ins_q   <= '0;
    end else if (rd_vld_q && (mode_q == PASS_SCAN)) begin
      if (rd_id == id_q) begin
        found_q <= 1'b1;
      end
      if (rd_exp <= key_q) begin
        ins_q <= ins_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (mode_q == PASS_SCAN) && (rd_id == id_q)) begin
      pos_q <= rd_idx_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_upd) begin
      case (op_q)
        OP_ADD:  cnt_d = cnt_q + CW'(1);
        OP_DEL:  cnt_d = cnt_q - CW'(1);
        OP_TICK: cnt_d = cnt_q - ins_q;
        default: cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result registers
  always_comb begin
    strobe_d = 1'b0;
    kind_d   = kind_q;
    fid_d    = fid_q;
    st_d     = st_q;
    last_d   = last_q;
    if (cmd_i.resp) begin
      strobe_d = 1'b1;
      kind_d   = KIND_STATUS;
      fid_d    = id_q;
      st_d     = cmd_i.resp_st;
      last_d   = 1'b1;
    end else if (cmd_i.resp_none) begin
      strobe_d = 1'b1;
      kind_d   = KIND_NONE;
      fid_d    = '0;
      st_d     = ST_OK;
      last_d   = 1'b1;
    end else if (rd_vld_q && (mode_q == PASS_EMIT)) begin
      strobe_d = 1'b1;
      kind_d   = KIND_FIRED;
      fid_d    = rd_id;
      st_d     = ST_OK;
      last_d   = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    fid_q  <= fid_d;
    st_q   <= st_d;
    last_q <= last_d;
  end

  assign sts_o.op        = op_q;
  assign sts_o.pass_done = (left_q == '0) && !rd_vld_q;
  assign sts_o.found     = found_q;
  assign sts_o.full      = (cnt_q >= CW'(DEPTH));
  assign sts_o.none_due  = (ins_q == '0);

  assign res_strobe_o = strobe_q;
  assign kind_o       = kind_q;
  assign fired_id_o   = fid_q;
  assign status_o     = st_q;
  assign last_o       = last_q;

endmodule

FILE: rtl/sorted_timer_queue.sv
// Sorted timer queue top level. N = stored timers (at most 16). After an item is accepted,
// busy stays high through a search walk, a decide step, then emit and shift walks and an
// insert write as the operation needs; the next item is taken once busy is low.
// A status result shows in the first cycle with busy low; expired timers show during the
// emit walk, one per cycle, one cycle each on res_strobe_o.
// Reset clears the entry count; table contents are unknown until written. No receiver stall.
`timescale 1ns / 1ps

module sorted_timer_queue import stq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      operation_i,
  input  logic [IDW-1:0]  timer_id_i,
  input  logic [TW-1:0]   expire_time_i,
  input  logic [TW-1:0]   now_time_i,
  output logic            res_strobe_o,
  output logic [1:0]      kind_o,
  output logic [IDW-1:0]  fired_id_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  cmd_t cmd;
  sts_t sts;

  stq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  stq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .timer_id_i    (timer_id_i),
    .expire_time_i (expire_time_i),
    .now_time_i    (now_time_i),
    .res_strobe_o  (res_strobe_o),
    .kind_o        (kind_o),
    .fired_id_o    (fired_id_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

FILE: rtl/stq_chk.sv
// Port-level checker for sorted_timer_queue, attached by bind.
// Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_chk import stq_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_strobe_o,
  input logic [1:0]     kind_o,
  input logic [IDW-1:0] fired_id_o,
  input logic           last_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result without an item in progress");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  a_none_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && kind_o == KIND_NONE) |-> (last_o && fired_id_o == '0))
    else $error("none-due result malformed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && kind_o == KIND_STATUS) |-> last_o)
    else $error("status result not final");

endmodule

bind sorted_timer_queue stq_chk u_stq_chk (.*);
